[hdl/alu16_flags_branch_test_core_assert.svh]
// assertion macros shared by the alu16 flags/branch core modules
// relies on clk_i and rst_ni being present in the including module
`ifndef ALU16_FLAGS_BRANCH_TEST_CORE_ASSERT_SVH
`define ALU16_FLAGS_BRANCH_TEST_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define AFBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define AFBT_ASSERT_IMP(lbl, ante, cons, msg) \
  `AFBT_ASSERT(lbl, (ante) |-> (cons), msg)
`define AFBT_ASSERT_NXT(lbl, ante, cons, msg) \
  `AFBT_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define AFBT_ASSERT(lbl, prop, msg)
`define AFBT_ASSERT_IMP(lbl, ante, cons, msg)
`define AFBT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[hdl/afbt_pkg.sv]
// shared types and constants for the alu16 flags/branch core
// no dependencies
package afbt_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned CNT_W  = $clog2(DATA_W);
  localparam int unsigned SHW    = $clog2(DATA_W);
  localparam int unsigned OP_W   = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 5'd0,
    OP_SUB = 5'd1,
    OP_MUL = 5'd2,
    OP_DIV = 5'd3,
    OP_SHL = 5'd4,
    OP_SHR = 5'd5,
    OP_AND = 5'd6,
    OP_OR  = 5'd7,
    OP_XOR = 5'd8,
    OP_NOT = 5'd9,
    OP_CMP = 5'd10,
    OP_MOV = 5'd11,
    OP_JMP = 5'd12,
    OP_JZ  = 5'd13,
    OP_JNZ = 5'd14,
    OP_JG  = 5'd15,
    OP_JL  = 5'd16,
    OP_JE  = 5'd17,
    OP_JNE = 5'd18,
    OP_JGE = 5'd19,
    OP_JLE = 5'd20
  } op_e;

  typedef struct packed {
    logic z;
    logic c;
    logic n;
    logic v;
  } flags_t;

  // request to the iterative multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_rsp_t;

endpackage

[hdl/alu16_flags_branch_test_core.sv]
// top level of the 16-bit alu with stored status flags and jump resolution
// uses afbt_pkg and afbt_muldiv
// Each input beat carries an opcode in tuser and two 16-bit operands in tdata; one result beat
// follows per input beat. Add, sub, cmp, shifts, logic ops, move and jumps skip the muldiv unit:
// the result register loads on the accept edge. Mul and div make one pass per operand bit through
// the shared add/subtract unit in afbt_muldiv, and the result register loads once it signals done.
// A new beat is taken when the block is not iterating and the result register is empty or being
// drained: simple ops can go at one item per cycle while results drain; mul/div blocks new beats.
// Jumps test the flags left by the previous item; divide by zero gives all ones and sets overflow.
`include "alu16_flags_branch_test_core_assert.svh"

module alu16_flags_branch_test_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [15:0] operand_a, [31:16] operand_b
  input  logic [7:0]  s_axis_tuser_i,   // [4:0] op, [7:5] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] result
  output logic [7:0]  m_axis_tuser_o    // write_back, branch_taken, zero_out, carry_out,
                                        // negative_out, overflow_out, [7:6] zero
);
  import afbt_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_e;

  state_e            state_q;
  logic              m_valid_q;
  logic [DATA_W-1:0] res_q;
  logic              wb_q;
  logic              tk_q;
  flags_t            flags_q;
  logic              div_q;
  logic              bzero_q;

  op_e               op;
  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic              accept;
  logic              is_md;

  logic [DATA_W:0]   add_s;
  logic [DATA_W:0]   sub_s;
  logic              sv;
  logic [DATA_W-1:0] r;
  logic              wb;
  logic              tk;
  flags_t            fl;

  md_req_t           md_req;
  md_rsp_t           md_rsp;
  logic [DATA_W-1:0] md_lo;
  logic [DATA_W-1:0] md_hi;
  flags_t            md_fl;

  assign op     = op_e'(s_axis_tuser_i[OP_W-1:0]);
  assign a      = s_axis_tdata_i[DATA_W-1:0];
  assign b      = s_axis_tdata_i[2*DATA_W-1:DATA_W];
  assign is_md  = (op == OP_MUL) || (op == OP_DIV);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready_i);

  assign md_req.start  = accept && is_md;
  assign md_req.is_div = (op == OP_DIV);

  afbt_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .a_i    (a),
    .b_i    (b),
    .rsp_o  (md_rsp),
    .lo_o   (md_lo),
    .hi_o   (md_hi)
  );

  // ops handled without the muldiv unit
  always_comb begin
    add_s = {1'b0, a} + {1'b0, b};
    sub_s = {1'b0, a} - {1'b0, b};
    sv    = flags_q.n ^ flags_q.v;
    r     = '0;
    wb    = 1'b0;
    tk    = 1'b0;
    fl    = flags_q;
    case (op)
      OP_ADD: begin
        r  = add_s[DATA_W-1:0];
        wb = 1'b1;
        fl = '{z: (r == '0), c: add_s[DATA_W], n: r[DATA_W-1],
               v: (a[DATA_W-1] ^ r[DATA_W-1]) & (b[DATA_W-1] ^ r[DATA_W-1])};
      end
      OP_SUB, OP_CMP: begin
        r  = sub_s[DATA_W-1:0];
        wb = (op == OP_SUB);
        fl = '{z: (r == '0), c: sub_s[DATA_W], n: r[DATA_W-1],
               v: (a[DATA_W-1] ^ b[DATA_W-1]) & (a[DATA_W-1] ^ r[DATA_W-1])};
      end
      OP_SHL, OP_SHR, OP_AND, OP_OR, OP_XOR, OP_NOT: begin
        case (op)
          OP_SHL:  r = (b[DATA_W-1:SHW] != '0) ? '0 : (a << b[SHW-1:0]);
          OP_SHR:  r = (b[DATA_W-1:SHW] != '0) ? '0 : (a >> b[SHW-1:0]);
          OP_AND:  r = a & b;
          OP_OR:   r = a | b;
          OP_XOR:  r = a ^ b;
          default: r = ~a;
        endcase
        wb = 1'b1;
        fl = '{z: (r == '0), c: 1'b0, n: r[DATA_W-1], v: 1'b0};
      end
      OP_MOV: begin
        r  = b;
        wb = 1'b1;
      end
      OP_JMP: begin
        r  = a;
        tk = 1'b1;
      end
      OP_JZ, OP_JE: begin
        r  = a;
        tk = flags_q.z;
      end
      OP_JNZ, OP_JNE: begin
        r  = a;
        tk = !flags_q.z;
      end
      OP_JG: begin
        r  = a;
        tk = !flags_q.z && !sv;
      end
      OP_JL: begin
        r  = a;
        tk = sv;
      end
      OP_JGE: begin
        r  = a;
        tk = !sv;
      end
      OP_JLE: begin
        r  = a;
        tk = flags_q.z || sv;
      end
      default: begin
        r  = '0;
      end
    endcase
  end

  // flags for a finished multiply or divide
  always_comb begin
    if (div_q) begin
      md_fl = '{z: (md_lo == '0), c: 1'b0, n: md_lo[DATA_W-1], v: bzero_q};
    end else begin
      md_fl = '{z: (md_lo == '0), c: (md_hi != '0), n: md_lo[DATA_W-1], v: (md_hi != '0)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      flags_q   <= '0;
      div_q     <= 1'b0;
      bzero_q   <= 1'b0;
    end else begin
      // drained beat, unless a simple op refills the register on this edge
      if (m_valid_q && m_axis_tready_i && !(accept && !is_md)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (is_md) begin
              state_q <= ST_BUSY;
              div_q   <= (op == OP_DIV);
              bzero_q <= (b == '0);
            end else begin
              m_valid_q <= 1'b1;
              res_q     <= r;
              wb_q      <= wb;
              tk_q      <= tk;
              flags_q   <= fl;
            end
          end
        end
        ST_BUSY: begin
          if (md_rsp.done) begin
            // restoring divide by zero already yields all ones
            state_q   <= ST_IDLE;
            m_valid_q <= 1'b1;
            res_q     <= md_lo;
            wb_q      <= 1'b1;
            tk_q      <= 1'b0;
            flags_q   <= md_fl;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = res_q;
  assign m_axis_tuser_o  = {2'b00, flags_q.v, flags_q.n, flags_q.c, flags_q.z, tk_q, wb_q};

  `AFBT_ASSERT_IMP(a_done_in_busy, md_rsp.done, state_q == ST_BUSY, "muldiv done outside busy")
  `AFBT_ASSERT_IMP(a_flags_with_beat, !$stable(flags_q), m_valid_q, "flags moved without result")
  `AFBT_ASSERT_NXT(a_simple_result, accept && !is_md, m_valid_q && state_q == ST_IDLE,
                   "single-cycle op produced no result")
  `AFBT_ASSERT_IMP(a_busy_unit, state_q == ST_BUSY && !md_rsp.done, md_rsp.busy,
                   "waiting on idle muldiv unit")

endmodule

[hdl/afbt_muldiv.sv]
// iterative multiply/divide unit: shift-add multiply and restoring divide
// on one shared add/subtract unit, one bit per cycle; uses afbt_pkg
`include "alu16_flags_branch_test_core_assert.svh"

module afbt_muldiv (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  afbt_pkg::md_req_t        req_i,
  input  logic [afbt_pkg::DATA_W-1:0] a_i,
  input  logic [afbt_pkg::DATA_W-1:0] b_i,
  output afbt_pkg::md_rsp_t        rsp_o,
  output logic [afbt_pkg::DATA_W-1:0] lo_o,
  output logic [afbt_pkg::DATA_W-1:0] hi_o
);
  import afbt_pkg::*;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_W - 1);

  logic [DATA_W:0]   hi_q;
  logic [DATA_W-1:0] lo_q;
  logic [DATA_W-1:0] b_q;
  logic              div_q;
  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;

  logic [DATA_W:0]   op_x;
  logic [DATA_W:0]   op_y;
  logic [DATA_W+1:0] sum;
  logic              no_borrow;
  logic [DATA_W:0]   mul_hi;

  // shared adder: adds for multiply, subtracts the divisor for divide
  always_comb begin
    op_x      = div_q ? {hi_q[DATA_W-1:0], lo_q[DATA_W-1]} : hi_q;
    op_y      = {1'b0, b_q} ^ {(DATA_W+1){div_q}};
    sum       = {1'b0, op_x} + {1'b0, op_y} + {{(DATA_W+1){1'b0}}, div_q};
    no_borrow = sum[DATA_W+1];
    mul_hi    = lo_q[0] ? sum[DATA_W:0] : hi_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        div_q  <= req_i.is_div;
        b_q    <= b_i;
        hi_q   <= '0;
        lo_q   <= a_i;
      end else if (busy_q) begin
        if (div_q) begin
          hi_q <= no_borrow ? sum[DATA_W:0] : op_x;
          lo_q <= {lo_q[DATA_W-2:0], no_borrow};
        end else begin
          hi_q <= {1'b0, mul_hi[DATA_W:1]};
          lo_q <= {mul_hi[0], lo_q[DATA_W-1:1]};
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign lo_o       = lo_q;
  assign hi_o       = hi_q[DATA_W-1:0];

  `AFBT_ASSERT_IMP(a_done_idle, done_q, !busy_q, "muldiv done while still iterating")
  `AFBT_ASSERT_NXT(a_start_busy, req_i.start, busy_q && cnt_q == '0, "muldiv start lost")
  `AFBT_ASSERT_NXT(a_keep_busy, busy_q && !req_i.start && cnt_q != LAST, busy_q && !done_q,
                   "muldiv stopped early")

endmodule

[tb/sv/testbench.sv]
// self-checking testbench for alu16_flags_branch_test_core
// uses afbt_pkg for opcodes and the flag struct; needs the core rtl and its muldiv unit
`timescale 1ns / 1ps

module testbench;
  import afbt_pkg::*;

  localparam logic [4:0] OP_UNUSED_LO = 5'd21;
  localparam logic [4:0] OP_UNUSED_HI = 5'd31;

  typedef struct packed {
    logic [15:0] result;
    logic        wb;
    logic        taken;
    flags_t      flags;
  } alu_beat_t;

  // predicts the alu result and stored flags for each accepted instruction
  class alu16_checker;
    flags_t      flags;
    alu_beat_t   pending_results[$];
    int unsigned n_issued;
    int unsigned n_checked;
    int unsigned n_taken;
    int unsigned n_errors;

    function new();
      flags = '0;
      n_issued = 0;
      n_checked = 0;
      n_taken = 0;
      n_errors = 0;
    endfunction

    function void predict_instr(logic [4:0] op, logic [15:0] a, logic [15:0] b);
      alu_beat_t   e;
      logic [16:0] sum;
      logic [31:0] prod;
      logic [15:0] res;
      logic        c;
      logic        v;
      logic        upd;
      logic        sv;
      e = '0;
      res = '0;
      c = 1'b0;
      v = 1'b0;
      upd = 1'b0;
      sv = flags.n != flags.v;
      case (op)
        OP_ADD: begin
          sum = {1'b0, a} + {1'b0, b};
          res = sum[15:0];
          c = sum[16];
          v = (a[15] == b[15]) && (res[15] != a[15]);
          upd = 1'b1;
          e.wb = 1'b1;
        end
        OP_SUB, OP_CMP: begin
          res = a - b;
          c = a < b;
          v = (a[15] != b[15]) && (res[15] != a[15]);
          upd = 1'b1;
          e.wb = (op == OP_SUB);
        end
        OP_MUL: begin
          prod = {16'd0, a} * {16'd0, b};
          res = prod[15:0];
          c = |prod[31:16];
          v = c;
          upd = 1'b1;
          e.wb = 1'b1;
        end
        OP_DIV: begin
          if (b == 16'd0) begin
            res = 16'hFFFF;
            v = 1'b1;
          end else begin
            res = a / b;
          end
          upd = 1'b1;
          e.wb = 1'b1;
        end
        OP_SHL: begin
          res = (b >= 16'd16) ? 16'd0 : (a << b[3:0]);
          upd = 1'b1;
          e.wb = 1'b1;
        end
        OP_SHR: begin
          res = (b >= 16'd16) ? 16'd0 : (a >> b[3:0]);
          upd = 1'b1;
          e.wb = 1'b1;
        end
        OP_AND: begin res = a & b; upd = 1'b1; e.wb = 1'b1; end
        OP_OR:  begin res = a | b; upd = 1'b1; e.wb = 1'b1; end
        OP_XOR: begin res = a ^ b; upd = 1'b1; e.wb = 1'b1; end
        OP_NOT: begin res = ~a;    upd = 1'b1; e.wb = 1'b1; end
        OP_MOV: begin res = b; e.wb = 1'b1; end
        OP_JMP: begin res = a; e.taken = 1'b1; end
        OP_JZ, OP_JE:   begin res = a; e.taken = flags.z; end
        OP_JNZ, OP_JNE: begin res = a; e.taken = !flags.z; end
        OP_JG:  begin res = a; e.taken = !flags.z && !sv; end
        OP_JL:  begin res = a; e.taken = sv; end
        OP_JGE: begin res = a; e.taken = !sv; end
        OP_JLE: begin res = a; e.taken = flags.z || sv; end
        default: ;
      endcase
      if (upd) begin
        flags.z = (res == 16'd0);
        flags.n = res[15];
        flags.c = c;
        flags.v = v;
      end
      e.result = res;
      e.flags = flags;
      if (e.taken) n_taken++;
      n_issued++;
      pending_results.push_back(e);
    endfunction

    function void check_result(logic [15:0] data, logic [7:0] user);
      alu_beat_t e;
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("%0t: result beat with nothing outstanding: data %h user %h",
                   $realtime, data, user);
        return;
      end
      e = pending_results.pop_front();
      n_checked++;
      if (data !== e.result || user[0] !== e.wb || user[1] !== e.taken ||
          user[2] !== e.flags.z || user[3] !== e.flags.c ||
          user[4] !== e.flags.n || user[5] !== e.flags.v) begin
        n_errors++;
        if (n_errors <= 10) begin
          $write("%0t: beat %0d mismatch: exp res %h wb %b tk %b zcnv %b%b%b%b, ",
                 $realtime, n_checked, e.result, e.wb, e.taken,
                 e.flags.z, e.flags.c, e.flags.n, e.flags.v);
          $display("got res %h wb %b tk %b zcnv %b%b%b%b",
                   data, user[0], user[1], user[2], user[3], user[4], user[5]);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [4:0]  s_op = '0;
  logic [15:0] s_a = '0;
  logic [15:0] s_b = '0;
  logic        m_ready = 1'b0;
  logic        steady = 1'b0;

  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;
  logic [7:0]  m_axis_tuser_o;

  alu16_checker sb = new();

  alu16_flags_branch_test_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  ({s_b, s_a}),
    .s_axis_tuser_i  ({3'b000, s_op}),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    m_ready <= steady || ($urandom_range(0, 99) >= 19);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready)
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
  end

  task automatic send_instr(input logic [4:0] op, input logic [15:0] a, input logic [15:0] b);
    while (!steady && $urandom_range(0, 99) < 19) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_op <= op;
    s_a <= a;
    s_b <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.predict_instr(op, a, b);
  endtask

  // corner values show up often so carries, overflows and sign flips are common
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return 16'h0001;
      5: return 16'($urandom_range(0, 31));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int unsigned k;
    logic [4:0]  op;
    logic [15:0] a;
    logic [15:0] b;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // carry and zero, then jumps on zero
    send_instr(OP_ADD, 16'hFFFF, 16'h0001);
    send_instr(OP_JZ,  16'h1234, 16'h0000);
    send_instr(OP_JNZ, 16'h1234, 16'hFFFF);
    // signed overflow into negative: n == v
    send_instr(OP_ADD, 16'h7FFF, 16'h0001);
    send_instr(OP_JL,  16'hABCD, 16'h0000);
    send_instr(OP_JGE, 16'hABCD, 16'h0000);
    // borrow, negative without overflow
    send_instr(OP_SUB, 16'h0000, 16'h0001);
    send_instr(OP_JG,  16'h0F0F, 16'h0000);
    send_instr(OP_JLE, 16'h0F0F, 16'h0000);
    // overflow with positive result
    send_instr(OP_SUB, 16'h8000, 16'h0001);
    send_instr(OP_CMP, 16'h1234, 16'h1234);
    send_instr(OP_JE,  16'hFFFF, 16'h0000);
    send_instr(OP_JNE, 16'hFFFF, 16'h0000);
    send_instr(OP_MUL, 16'hFFFF, 16'hFFFF);
    send_instr(OP_MUL, 16'h00FF, 16'h0101);
    // divide by zero
    send_instr(OP_DIV, 16'h1234, 16'h0000);
    send_instr(OP_DIV, 16'hFFFF, 16'h0001);
    send_instr(OP_SHL, 16'h0001, 16'h000F);
    send_instr(OP_SHL, 16'hFFFF, 16'h0010);
    send_instr(OP_SHR, 16'hFFFF, 16'hFFFF);
    send_instr(OP_AND, 16'hF0F0, 16'h3C3C);
    send_instr(OP_OR,  16'h0000, 16'h0000);
    send_instr(OP_XOR, 16'hAAAA, 16'h5555);
    send_instr(OP_NOT, 16'h0000, 16'h1111);
    send_instr(OP_MOV, 16'h4321, 16'h8765);
    send_instr(OP_JMP, 16'h5A5A, 16'hA5A5);
    send_instr(OP_UNUSED_LO, 16'hFFFF, 16'hFFFF);
    send_instr(OP_UNUSED_HI, 16'h1357, 16'h2468);

    for (k = 0; k < 1600; k++) begin
      steady = (k >= 700 && k < 1000);
      if ($urandom_range(0, 99) < 3)
        op = 5'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      else
        op = 5'($urandom_range(0, 20));
      a = pick_operand();
      b = pick_operand();
      // keep most shift counts near the word size
      if ((op == OP_SHL || op == OP_SHR) && $urandom_range(0, 3) != 0)
        b = 16'($urandom_range(0, 20));
      send_instr(op, a, b);
    end
    steady = 1'b0;
    s_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("summary: %0d instructions sent, %0d result beats compared, %0d jumps taken",
             sb.n_issued, sb.n_checked, sb.n_taken);
    $display("summary: %0d mismatching or unexpected beats", sb.n_errors);
    if (sb.n_errors == 0 && sb.pending_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d results still outstanding", sb.pending_results.size());
    $display("testbench: done, errors");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/afbt_pkg.sv
hdl/afbt_muldiv.sv
hdl/alu16_flags_branch_test_core.sv
tb/sv/testbench.sv
